// ----- hdl/dbtc_pkg.sv -----
`default_nettype none
package dbtc_pkg;
  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] RegView   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegRight  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegUp     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegOrigin = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegSize   = 3'd4;

  typedef enum logic [1:0] {
    VerdictKept    = 2'd0,
    VerdictDecal   = 2'd1,
    VerdictBack    = 2'd2,
    VerdictOutside = 2'd3
  } verdict_e;
endpackage
`default_nettype wire

// ----- hdl/dbtc_cfg_regs.sv -----
`default_nettype none
module dbtc_cfg_regs #(
  parameter int unsigned VecWidth = 48
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dbtc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [VecWidth-1:0]              cfg_data_i,
  output logic      [VecWidth-1:0]              view_o,
  output logic      [VecWidth-1:0]              right_o,
  output logic      [VecWidth-1:0]              up_o,
  output logic      [VecWidth-1:0]              origin_o,
  output logic      [VecWidth-1:0]              size_o
);
  import dbtc_pkg::*;

  logic [VecWidth-1:0] view_q, right_q, up_q, origin_q, size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q   <= '0;
      right_q  <= '0;
      up_q     <= '0;
      origin_q <= '0;
      size_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegView:   view_q   <= cfg_data_i;
        RegRight:  right_q  <= cfg_data_i;
        RegUp:     up_q     <= cfg_data_i;
        RegOrigin: origin_q <= cfg_data_i;
        RegSize:   size_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign view_o   = view_q;
  assign right_o  = right_q;
  assign up_o     = up_q;
  assign origin_o = origin_q;
  assign size_o   = size_q;
endmodule
`default_nettype wire

// ----- hdl/dbtc_plane_terms.sv -----
`default_nettype none
// Per-item plane constants. They depend on configuration only, but are
// registered in two stages so that each multiply sits alone between flops.
module dbtc_plane_terms #(
  parameter int unsigned CoordWidth = 16,
  parameter int unsigned ExtWidth   = 72
) (
  input  wire logic                    clk_i,
  input  wire logic [3*CoordWidth-1:0] view_i,
  input  wire logic [3*CoordWidth-1:0] right_i,
  input  wire logic [3*CoordWidth-1:0] up_i,
  input  wire logic [3*CoordWidth-1:0] size_i,
  output logic signed [ExtWidth-1:0]   far_o,
  output logic signed [ExtWidth-1:0]   left_o,
  output logic signed [ExtWidth-1:0]   right_o,
  output logic signed [ExtWidth-1:0]   bottom_o,
  output logic signed [ExtWidth-1:0]   top_o
);
  localparam int unsigned W = CoordWidth;
  localparam int unsigned DotW = 2 * W + 2;

  logic signed [DotW-1:0] rv_q, uv_q, rr_q, uu_q, vv_q;
  logic signed [W:0]      sx_q, sy_q, sz_q;
  logic signed [ExtWidth-1:0] zv, zu, xr, yu, fe;

  function automatic logic signed [DotW-1:0] dot3(input logic [3*W-1:0] a,
                                                  input logic [3*W-1:0] b);
    logic signed [DotW-1:0] s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      s = s + DotW'($signed(a[k*W +: W]) * $signed(b[k*W +: W]));
    end
    return s;
  endfunction

  always_ff @(posedge clk_i) begin
    rv_q <= dot3(right_i, view_i);
    uv_q <= dot3(up_i, view_i);
    rr_q <= dot3(right_i, right_i);
    uu_q <= dot3(up_i, up_i);
    vv_q <= dot3(view_i, view_i);
    sx_q <= $signed({1'b0, size_i[0 +: W]});
    sy_q <= $signed({1'b0, size_i[W +: W]});
    sz_q <= $signed({1'b0, size_i[2*W +: W]});
  end

  assign zv = ExtWidth'(sz_q * rv_q);
  assign zu = ExtWidth'(sz_q * uv_q);
  assign xr = ExtWidth'(sx_q * rr_q);
  assign yu = ExtWidth'(sy_q * uu_q);
  assign fe = ExtWidth'(sz_q * vv_q) <<< 1;

  always_ff @(posedge clk_i) begin
    far_o    <= fe;
    left_o   <= xr - zv;
    right_o  <= xr + zv;
    bottom_o <= yu + zu;
    top_o    <= yu - zu;
  end
endmodule
`default_nettype wire

// ----- hdl/dbtc_vertex_dots.sv -----
`default_nettype none
// Stage pair for one vertex: subtract origin, then the three axis dots.
module dbtc_vertex_dots #(
  parameter int unsigned CoordWidth = 16
) (
  input  wire logic                      clk_i,
  input  wire logic [3*CoordWidth-1:0]   vertex_i,
  input  wire logic [3*CoordWidth-1:0]   origin_i,
  input  wire logic [3*CoordWidth-1:0]   view_i,
  input  wire logic [3*CoordWidth-1:0]   right_i,
  input  wire logic [3*CoordWidth-1:0]   up_i,
  output logic signed [2*CoordWidth+3:0] vd_o,
  output logic signed [2*CoordWidth+3:0] rd_o,
  output logic signed [2*CoordWidth+3:0] ud_o
);
  localparam int unsigned W = CoordWidth;
  localparam int unsigned DotW = 2 * W + 4;

  logic signed [W:0] d_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d_q[k] <= (W+1)'($signed(vertex_i[k*W +: W])) - (W+1)'($signed(origin_i[k*W +: W]));
    end
  end

  function automatic logic signed [DotW-1:0] dotd(input logic [3*W-1:0] a,
                                                  input logic signed [W:0] d0,
                                                  input logic signed [W:0] d1,
                                                  input logic signed [W:0] d2);
    logic signed [DotW-1:0] s;
    s = DotW'($signed(a[0 +: W]) * d0) + DotW'($signed(a[W +: W]) * d1)
      + DotW'($signed(a[2*W +: W]) * d2);
    return s;
  endfunction

  always_ff @(posedge clk_i) begin
    vd_o <= dotd(view_i, d_q[0], d_q[1], d_q[2]);
    rd_o <= dotd(right_i, d_q[0], d_q[1], d_q[2]);
    ud_o <= dotd(up_i, d_q[0], d_q[1], d_q[2]);
  end
endmodule
`default_nettype wire

// ----- hdl/decal_box_triangle_cull_unit.sv -----
`default_nettype none
// Triangle culler against a decal box.
// Configuration: cfg_we_i / cfg_idx_i / cfg_data_i write one of five frame
// registers (view, right, up, origin, size) at a clock edge; indexes above
// four are ignored. Write them only while no triangle is in flight.
// Input: a triangle is taken at each edge with start high; busy is tied
// low, so one triangle per cycle is accepted, back to back.
// Output: done_o pulses for one cycle with keep_o, verdict_o and the three
// vertices. After the accepting edge a triangle passes registered stages:
// origin subtract, axis dots, scaled plane sums with compare, verdict. The
// facing test runs alongside over the first two stages. The plane constants
// are derived from configuration in two registered stages.
// The receiver cannot stall; results leave in order, one per triangle.
// Reset clears the frame registers to zero and empties the pipeline.
module decal_box_triangle_cull_unit #(
  parameter int unsigned CoordWidth = dbtc_pkg::CoordWidthDef,
  parameter int unsigned FracBits   = dbtc_pkg::FracBitsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dbtc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [3*CoordWidth-1:0]          cfg_data_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [3*CoordWidth-1:0]          vertex_a_i,
  input  wire logic [3*CoordWidth-1:0]          vertex_b_i,
  input  wire logic [3*CoordWidth-1:0]          vertex_c_i,
  input  wire logic [3*CoordWidth-1:0]          face_normal_i,
  input  wire logic                             is_decal_face_i,
  output logic                                  done_o,
  output logic                                  keep_o,
  output logic [1:0]                            verdict_o,
  output logic [3*CoordWidth-1:0]               out_vertex_a_o,
  output logic [3*CoordWidth-1:0]               out_vertex_b_o,
  output logic [3*CoordWidth-1:0]               out_vertex_c_o
);
  import dbtc_pkg::*;

  localparam int unsigned W = CoordWidth;
  localparam int unsigned VW = 3 * W;
  localparam int unsigned DotW = 2 * W + 4;
  localparam int unsigned ExtW = 3 * W + 24;
  localparam int unsigned SumW = ExtW + FracBits + 4;
  localparam int unsigned NLat = 4;

  logic [VW-1:0] view, rgt, up, origin, size;
  logic signed [ExtW-1:0] far_e, left_e, right_e, bot_e, top_e;

  assign busy = 1'b0;

  dbtc_cfg_regs #(.VecWidth(VW)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .view_o(view), .right_o(rgt), .up_o(up), .origin_o(origin), .size_o(size)
  );

  dbtc_plane_terms #(.CoordWidth(W), .ExtWidth(ExtW)) u_terms (
    .clk_i, .view_i(view), .right_i(rgt), .up_i(up), .size_i(size),
    .far_o(far_e), .left_o(left_e), .right_o(right_e),
    .bottom_o(bot_e), .top_o(top_e)
  );

  // stage 1: normal dot and flags; vertex pipes carried along
  logic [NLat-1:0] vld_q;
  logic [VW-1:0] va_q [NLat], vb_q [NLat], vc_q [NLat];
  logic [1:0] pre_q [2];
  logic signed [DotW-1:0] nv, nv_q;
  logic decal_q;
  logic signed [DotW+10:0] nv1000;

  always_comb begin
    nv = '0;
    for (int k = 0; k < 3; k++) begin
      nv = nv + DotW'($signed(face_normal_i[k*W +: W]) * $signed(view[k*W +: W]));
    end
  end
  assign nv1000 = (DotW+11)'(nv_q) * (DotW+11)'(1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NLat-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    va_q[0] <= vertex_a_i;
    vb_q[0] <= vertex_b_i;
    vc_q[0] <= vertex_c_i;
    for (int s = 1; s < NLat; s++) begin
      va_q[s] <= va_q[s-1];
      vb_q[s] <= vb_q[s-1];
      vc_q[s] <= vc_q[s-1];
    end
    nv_q    <= nv;
    decal_q <= is_decal_face_i;
    // stage 2: decal and facing verdicts
    if (decal_q) begin
      pre_q[0] <= VerdictDecal;
    end else if (nv1000 < (DotW+11)'(1) <<< (2 * FracBits)) begin
      pre_q[0] <= VerdictBack;
    end else begin
      pre_q[0] <= VerdictKept;
    end
    pre_q[1] <= pre_q[0];
  end

  // stages 1-2: per-vertex axis dots
  logic signed [DotW-1:0] vd [3], rd [3], ud [3];
  logic [VW-1:0] verts [3];
  assign verts[0] = vertex_a_i;
  assign verts[1] = vertex_b_i;
  assign verts[2] = vertex_c_i;

  for (genvar i = 0; i < 3; i++) begin : g_vtx
    dbtc_vertex_dots #(.CoordWidth(W)) u_dots (
      .clk_i, .vertex_i(verts[i]), .origin_i(origin), .view_i(view),
      .right_i(rgt), .up_i(up), .vd_o(vd[i]), .rd_o(rd[i]), .ud_o(ud[i])
    );
  end

  // stage 3: scaled sums and sign tests
  logic [5:0] behind [3];
  logic [5:0] behind_q [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [SumW-1:0] sv, sr, su;
      sv = SumW'(vd[i]) <<< (FracBits + 1);
      sr = SumW'(rd[i]) <<< (FracBits + 1);
      su = SumW'(ud[i]) <<< (FracBits + 1);
      behind[i][0] = (-sv) <= 0;
      behind[i][1] = (sv + SumW'(far_e)) <= 0;
      behind[i][2] = (SumW'(left_e) - sr) <= 0;
      behind[i][3] = (sr + SumW'(right_e)) <= 0;
      behind[i][4] = (su + SumW'(bot_e)) <= 0;
      behind[i][5] = (SumW'(top_e) - su) <= 0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      behind_q[i] <= behind[i];
    end
  end

  // stage 4: verdict
  logic out_any;
  logic [1:0] verdict_d;
  assign out_any = |(behind_q[0] & behind_q[1] & behind_q[2]);
  always_comb begin
    verdict_d = pre_q[1];
    if (pre_q[1] == VerdictKept && out_any) begin
      verdict_d = VerdictOutside;
    end
  end

  logic [1:0] verdict_q;
  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign done_o         = vld_q[NLat-1];
  assign verdict_o      = verdict_q;
  assign keep_o         = (verdict_q == VerdictKept);
  assign out_vertex_a_o = va_q[NLat-1];
  assign out_vertex_b_o = vb_q[NLat-1];
  assign out_vertex_c_o = vc_q[NLat-1];

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##4 done_o) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 4)) else $error("spurious result");
  a_keep_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (keep_o == (verdict_o == VerdictKept))) else $error("keep mismatch");
`endif
endmodule
`default_nettype wire
